// ----- hdl/fdsc_pkg.sv -----
package fdsc_pkg;

    localparam int WINDOW_DEPTH = 5;

    localparam logic [7:0] START_ONE_RESET = 8'd170;
    localparam logic [7:0] START_TWO_RESET = 8'd85;

    localparam logic [7:0] CFG_START_ONE = 8'd0;
    localparam logic [7:0] CFG_START_TWO = 8'd1;

    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_READ   = 2'd1,
        PH_CHECK  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        EV_PAYLOAD = 2'd0,
        EV_GOOD    = 2'd1,
        EV_BAD     = 2'd2
    } event_t;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [7:0]  command;
        logic [15:0] frame_length;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
    } result_t;

    typedef struct packed {
        logic valid;
        logic [7:0] index;
        logic [7:0] data;
    } cfg_write_t;

endpackage

// ----- hdl/fdsc_deframer.sv -----
module fdsc_deframer (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  fdsc_pkg::cfg_write_t  cfg_wr,
    input  logic                  in_accept,
    input  logic [7:0]            in_byte,
    output logic                  res_valid,
    output fdsc_pkg::result_t     res
);

    logic [7:0] start_one_reg, start_one_next;
    logic [7:0] start_two_reg, start_two_next;

    logic [7:0] win_reg [fdsc_pkg::WINDOW_DEPTH];
    logic [7:0] win_next [fdsc_pkg::WINDOW_DEPTH];

    fdsc_pkg::phase_t phase_reg, phase_next;
    logic [15:0] left_reg, left_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [15:0] len_reg, len_next;

    logic [7:0]  hdr_sum;
    logic [15:0] hdr_len;
    logic        hdr_hit;

    assign hdr_sum = win_reg[0] + win_reg[1] + win_reg[2] + win_reg[3] + win_reg[4];
    assign hdr_len = {win_reg[3], win_reg[4]};
    assign hdr_hit = (win_reg[0] == start_one_reg) && (win_reg[1] == start_two_reg)
                     && (in_byte == ~hdr_sum);

    always_comb begin
        start_one_next = start_one_reg;
        start_two_next = start_two_reg;
        if (cfg_wr.valid) begin
            unique case (cfg_wr.index)
                fdsc_pkg::CFG_START_ONE: start_one_next = cfg_wr.data;
                fdsc_pkg::CFG_START_TWO: start_two_next = cfg_wr.data;
                default: ;
            endcase
        end
    end

    // Next phase.
    always_comb begin
        phase_next = phase_reg;
        if (in_accept) begin
            unique case (phase_reg)
                fdsc_pkg::PH_READ:
                    phase_next = (left_reg == 16'd1) ? fdsc_pkg::PH_CHECK : fdsc_pkg::PH_READ;
                fdsc_pkg::PH_CHECK:
                    phase_next = fdsc_pkg::PH_SEARCH;
                default:
                    phase_next = (hdr_hit && (hdr_len != 16'd0)) ? fdsc_pkg::PH_READ
                                                                 : fdsc_pkg::PH_SEARCH;
            endcase
        end
    end

    // Datapath and result.
    always_comb begin
        win_next  = win_reg;
        left_next = left_reg;
        sum_next  = sum_reg;
        cmd_next  = cmd_reg;
        len_next  = len_reg;
        res_valid = 1'b0;
        res.event_res     = fdsc_pkg::EV_PAYLOAD;
        res.command       = cmd_reg;
        res.frame_length  = len_reg;
        res.payload_byte  = 8'd0;
        res.payload_index = 16'd0;
        unique case (phase_reg)
            fdsc_pkg::PH_READ: begin
                sum_next  = sum_reg + in_byte;
                left_next = left_reg - 16'd1;
                res_valid = in_accept;
                res.payload_byte  = in_byte;
                res.payload_index = len_reg - left_reg;
            end
            fdsc_pkg::PH_CHECK: begin
                res_valid = in_accept;
                if (in_byte == ~sum_reg) begin
                    res.event_res = fdsc_pkg::EV_GOOD;
                end else begin
                    res.event_res = fdsc_pkg::EV_BAD;
                    for (int i = 0; i < fdsc_pkg::WINDOW_DEPTH; i++) begin
                        win_next[i] = 8'd0;
                    end
                end
            end
            default: begin
                for (int i = 0; i < fdsc_pkg::WINDOW_DEPTH - 1; i++) begin
                    win_next[i] = win_reg[i + 1];
                end
                win_next[fdsc_pkg::WINDOW_DEPTH - 1] = in_byte;
                if (hdr_hit) begin
                    cmd_next = win_reg[2];
                    len_next = hdr_len;
                    // A header with no payload completes the frame at once.
                    if (hdr_len == 16'd0) begin
                        res_valid          = in_accept;
                        res.event_res      = fdsc_pkg::EV_GOOD;
                        res.command        = win_reg[2];
                        res.frame_length   = hdr_len;
                    end else begin
                        left_next = hdr_len;
                        sum_next  = 8'd0;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_one_reg <= fdsc_pkg::START_ONE_RESET;
            start_two_reg <= fdsc_pkg::START_TWO_RESET;
            for (int i = 0; i < fdsc_pkg::WINDOW_DEPTH; i++) begin
                win_reg[i] <= 8'd0;
            end
            phase_reg <= fdsc_pkg::PH_SEARCH;
            left_reg  <= 16'd0;
            sum_reg   <= 8'd0;
            cmd_reg   <= 8'd0;
            len_reg   <= 16'd0;
        end else begin
            start_one_reg <= start_one_next;
            start_two_reg <= start_two_next;
            phase_reg     <= phase_next;
            if (in_accept) begin
                win_reg  <= win_next;
                left_reg <= left_next;
                sum_reg  <= sum_next;
                cmd_reg  <= cmd_next;
                len_reg  <= len_next;
            end
        end
    end

endmodule

// ----- hdl/fdsc_skid.sv -----
module fdsc_skid (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_valid,
    input  fdsc_pkg::result_t  wr_data,
    output logic               wr_space,
    output logic               m_valid,
    input  logic               m_ready,
    output fdsc_pkg::result_t  m_data
);

    logic              main_valid_reg, main_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    fdsc_pkg::result_t main_reg, main_next;
    fdsc_pkg::result_t skid_reg, skid_next;

    // Input is taken only while the skid slot is free, so a result can always land.
    assign wr_space = !skid_valid_reg;
    assign m_valid  = main_valid_reg;
    assign m_data   = main_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || m_ready) begin
            main_valid_next = skid_valid_reg || wr_valid;
            main_next       = skid_valid_reg ? skid_reg : wr_data;
            skid_valid_next = skid_valid_reg && wr_valid;
            skid_next       = wr_data;
        end else if (wr_valid) begin
            skid_valid_next = 1'b1;
            skid_next       = wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

// ----- hdl/frame_deframer_sum_checksum.sv -----
// Byte-serial receive deframer with inverted-sum header and payload checksums.
// Input channel s_*: one received byte per transfer. Result channel m_*: at most
// one result per byte: a payload byte (event 0), frame good (1) or payload
// checksum bad (2), with the header's command and length attached.
// Configuration channel cfg_*: index 0 sets the first start byte, index 1 the
// second; other indices are ignored. cfg_ready is always high.
// Throughput is one byte per cycle while s_ready is high: the header test,
// window shift and running sum all complete between the byte's acceptance and
// the output buffer, whose result register drives m_valid.
// A two-entry output buffer (result register plus skid slot) separates the
// channels; s_ready drops only when both entries are full, so a receiver
// stall holds off input once a further result has filled the skid slot.
// Reset restores the start bytes to 0xAA and 0x55, clears the search window
// and running state, and empties the output buffer.
module frame_deframer_sum_checksum (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_event_res,
    output logic [7:0]  m_command,
    output logic [15:0] m_frame_length,
    output logic [7:0]  m_payload_byte,
    output logic [15:0] m_payload_index
);

    fdsc_pkg::cfg_write_t cfg_wr;
    fdsc_pkg::result_t    res;
    fdsc_pkg::result_t    out_data;
    logic                 res_valid;
    logic                 space;
    logic                 accept;

    assign cfg_ready    = 1'b1;
    assign cfg_wr.valid = cfg_valid;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    assign s_ready = space;
    assign accept  = s_valid && space;

    fdsc_deframer u_deframer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr    (cfg_wr),
        .in_accept (accept),
        .in_byte   (s_rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    fdsc_skid u_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (res_valid),
        .wr_data  (res),
        .wr_space (space),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (out_data)
    );

    assign m_event_res     = out_data.event_res;
    assign m_command       = out_data.command;
    assign m_frame_length  = out_data.frame_length;
    assign m_payload_byte  = out_data.payload_byte;
    assign m_payload_index = out_data.payload_index;

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

// Tracks the deframer state byte by byte and holds the results it owes.
class frame_tracker;
    logic [7:0]        start_one;
    logic [7:0]        start_two;
    logic [7:0]        window [fdsc_pkg::WINDOW_DEPTH];
    fdsc_pkg::phase_t  phase;
    logic [15:0]       bytes_left;
    logic [7:0]        running_sum;
    logic [7:0]        held_cmd;
    logic [15:0]       held_len;
    fdsc_pkg::result_t pending [$];
    int                mismatches;
    int                checked;
    int                payload_seen;
    int                good_frames;
    int                bad_frames;

    function new();
        start_one   = fdsc_pkg::START_ONE_RESET;
        start_two   = fdsc_pkg::START_TWO_RESET;
        foreach (window[i]) window[i] = 8'h00;
        phase       = fdsc_pkg::PH_SEARCH;
        bytes_left  = '0;
        running_sum = '0;
        held_cmd    = '0;
        held_len    = '0;
        mismatches  = 0;
        checked     = 0;
        payload_seen = 0;
        good_frames = 0;
        bad_frames  = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [7:0] value);
        if (idx == fdsc_pkg::CFG_START_ONE) begin
            start_one = value;
        end else if (idx == fdsc_pkg::CFG_START_TWO) begin
            start_two = value;
        end
    endfunction

    function fdsc_pkg::result_t make_result(fdsc_pkg::event_t ev, logic [7:0] pbyte,
                                            logic [15:0] pidx);
        fdsc_pkg::result_t r;
        r.event_res     = ev;
        r.command       = held_cmd;
        r.frame_length  = held_len;
        r.payload_byte  = pbyte;
        r.payload_index = pidx;
        return r;
    endfunction

    function string describe(fdsc_pkg::result_t r);
        return $sformatf("ev=%0d cmd=%02h len=%0d byte=%02h idx=%0d", r.event_res,
                         r.command, r.frame_length, r.payload_byte, r.payload_index);
    endfunction

    function void take_byte(logic [7:0] b);
        logic [7:0]  sum;
        logic [7:0]  inv;
        logic [7:0]  cmd_w;
        logic [15:0] len_w;
        logic        hit;
        case (phase)
            fdsc_pkg::PH_READ: begin
                pending.push_back(make_result(fdsc_pkg::EV_PAYLOAD, b, held_len - bytes_left));
                running_sum = running_sum + b;
                bytes_left  = bytes_left - 16'd1;
                if (bytes_left == 16'd0) phase = fdsc_pkg::PH_CHECK;
            end
            fdsc_pkg::PH_CHECK: begin
                phase = fdsc_pkg::PH_SEARCH;
                inv = ~running_sum;
                if (b == inv) begin
                    pending.push_back(make_result(fdsc_pkg::EV_GOOD, 8'h00, 16'h0000));
                end else begin
                    // A failed payload check throws away the whole window.
                    foreach (window[i]) window[i] = 8'h00;
                    pending.push_back(make_result(fdsc_pkg::EV_BAD, 8'h00, 16'h0000));
                end
            end
            default: begin
                phase = fdsc_pkg::PH_SEARCH;
                sum = window[0] + window[1] + window[2] + window[3] + window[4];
                inv = ~sum;
                hit = (window[0] == start_one) && (window[1] == start_two) && (b == inv);
                cmd_w = window[2];
                len_w = {window[3], window[4]};
                for (int i = 0; i < fdsc_pkg::WINDOW_DEPTH - 1; i++) window[i] = window[i + 1];
                window[fdsc_pkg::WINDOW_DEPTH - 1] = b;
                if (hit) begin
                    held_cmd = cmd_w;
                    held_len = len_w;
                    if (len_w == 16'd0) begin
                        pending.push_back(make_result(fdsc_pkg::EV_GOOD, 8'h00, 16'h0000));
                    end else begin
                        bytes_left  = len_w;
                        running_sum = 8'h00;
                        phase       = fdsc_pkg::PH_READ;
                    end
                end
            end
        endcase
    endfunction

    function void match_result(fdsc_pkg::result_t got);
        fdsc_pkg::result_t want;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Unexpected result with nothing pending: %s", describe(got));
            end
            return;
        end
        want = pending.pop_front();
        checked++;
        if (got.event_res !== want.event_res || got.command !== want.command ||
            got.frame_length !== want.frame_length ||
            got.payload_byte !== want.payload_byte ||
            got.payload_index !== want.payload_index) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Mismatch at result %0d: expected %s, got %s", checked,
                         describe(want), describe(got));
            end
        end else if (want.event_res == fdsc_pkg::EV_PAYLOAD) begin
            payload_seen++;
        end else if (want.event_res == fdsc_pkg::EV_GOOD) begin
            good_frames++;
        end else begin
            bad_frames++;
        end
    endfunction
endclass

module tb_top;

    localparam int ITEM_TARGET = 1450;
    localparam int PHASE_ITEMS = 110;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_event_res;
    logic [7:0]  m_command;
    logic [15:0] m_frame_length;
    logic [7:0]  m_payload_byte;
    logic [15:0] m_payload_index;

    frame_tracker tracker;
    logic [7:0]   marker_one;
    logic [7:0]   marker_two;
    bit           tx_steady;
    bit           rx_steady;
    bit           hold_request;
    int           bytes_sent;
    int           settings_used;
    int           idle_cycles = 0;

    frame_deframer_sum_checksum dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_res    (m_event_res),
        .m_command      (m_command),
        .m_frame_length (m_frame_length),
        .m_payload_byte (m_payload_byte),
        .m_payload_index(m_payload_index)
    );

    always #5 aclk = ~aclk;

    // Mostly short gaps, now and then a long one.
    function automatic int draw_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Results are checked before the byte of the same edge is noted, so the
    // expectations stay in transfer order.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                tracker.match_result({m_event_res, m_command, m_frame_length,
                                      m_payload_byte, m_payload_index});
            end
            if (cfg_valid && cfg_ready) tracker.write_reg(cfg_index, cfg_data);
            if (s_valid && s_ready) tracker.take_byte(s_rx_byte);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT) begin
                $display("No transfer for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, tracker.pending.size());
                $display("[frame_deframer_sum_checksum] ERROR");
                $finish;
            end
        end
    end

    initial begin : receiver
        int low_len;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (rx_steady || $urandom_range(0, 99) < 65) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                low_len = draw_gap() + 1;
                m_ready <= 1'b0;
                repeat (low_len) @(posedge aclk);
            end
        end
    end

    // Called at a clock edge; returns at the edge where the byte transfers.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_steady ? 0 : draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    task automatic send_header(input logic [7:0] one, input logic [7:0] two,
                               input logic [7:0] cmd, input logic [15:0] len,
                               input logic [7:0] flip);
        logic [7:0] sum;
        sum = one + two + cmd + len[15:8] + len[7:0];
        send_byte(one);
        send_byte(two);
        send_byte(cmd);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        send_byte(~sum ^ flip);
    endtask

    task automatic send_frame(input logic [7:0] cmd, input logic [15:0] len, input bit bad);
        logic [7:0] psum;
        logic [7:0] b;
        logic [7:0] tail;
        send_header(marker_one, marker_two, cmd, len, 8'h00);
        if (len != 16'd0) begin
            psum = 8'h00;
            for (int i = 0; i < len; i++) begin
                b = 8'($urandom_range(0, 255));
                psum = psum + b;
                send_byte(b);
            end
            tail = ~psum;
            if (bad) tail = tail ^ 8'($urandom_range(1, 255));
            send_byte(tail);
        end
    endtask

    task automatic send_episode();
        int          pick;
        int          n;
        logic [15:0] len;
        logic [7:0]  flip;
        pick = $urandom_range(0, 99);
        flip = 8'($urandom_range(1, 255));
        if (pick < 70) begin
            n = $urandom_range(0, 99);
            if (n < 35) len = 16'd0;
            else if (n < 85) len = 16'($urandom_range(1, 8));
            else len = 16'($urandom_range(9, 24));
            send_frame(8'($urandom_range(0, 255)), len, $urandom_range(0, 4) == 0);
        end else if (pick < 80) begin
            // Header whose own checksum is off.
            send_header(marker_one, marker_two, 8'($urandom_range(0, 255)),
                        16'($urandom_range(0, 65535)), flip);
        end else if (pick < 88) begin
            if ($urandom_range(0, 1)) begin
                send_header(marker_one ^ flip, marker_two, 8'($urandom_range(0, 255)),
                            16'($urandom_range(0, 24)), 8'h00);
            end else begin
                send_header(marker_one, marker_two ^ flip, 8'($urandom_range(0, 255)),
                            16'($urandom_range(0, 24)), 8'h00);
            end
        end else begin
            n = $urandom_range(1, 6);
            repeat (n) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(input logic [7:0] one, input logic [7:0] two);
        write_reg(fdsc_pkg::CFG_START_ONE, one);
        write_reg(fdsc_pkg::CFG_START_TWO, two);
        marker_one = one;
        marker_two = two;
        settings_used++;
    endtask

    // Stops offering bytes and waits until every owed result has come out,
    // plus a few cycles for a byte that owes nothing.
    task automatic settle_block();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin : main
        int phase_no;
        int phase_end;
        tracker      = new();
        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = 8'h00;
        cfg_data     = 8'h00;
        s_valid      = 1'b0;
        s_rx_byte    = 8'h00;
        tx_steady    = 1'b0;
        rx_steady    = 1'b0;
        hold_request = 1'b0;
        bytes_sent   = 0;
        settings_used = 0;
        marker_one   = fdsc_pkg::START_ONE_RESET;
        marker_two   = fdsc_pkg::START_TWO_RESET;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed frames on the reset start bytes.
        send_header(marker_one, marker_two, 8'h00, 16'd0, 8'h00);
        send_header(marker_one, marker_two, 8'hFF, 16'd1, 8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_header(marker_one, marker_two, 8'h3C, 16'hFFFF, 8'h01);
        send_header(marker_one, marker_two, 8'h5A, 16'd2, 8'h00);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'h7E);

        phase_no = 0;
        while (bytes_sent < ITEM_TARGET) begin
            settle_block();
            case (phase_no)
                0: begin
                    write_reg(8'($urandom_range(2, 255)), 8'($urandom_range(0, 255)));
                    configure(fdsc_pkg::START_ONE_RESET, fdsc_pkg::START_TWO_RESET);
                end
                1: configure(8'h00, 8'hFF);
                2: configure(8'hFF, 8'h00);
                3: configure(8'h00, 8'h00);
                4: configure(8'hFF, 8'hFF);
                default: begin
                    if ($urandom_range(0, 1)) begin
                        write_reg(8'($urandom_range(2, 255)), 8'($urandom_range(0, 255)));
                    end
                    configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                end
            endcase
            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            if (phase_no == 1) begin
                send_frame(8'($urandom_range(0, 255)), 16'd300, 1'b0);
            end else if (phase_no == 2) begin
                // Receiver holds off while bytes keep coming back to back.
                tx_steady    = 1'b1;
                hold_request = 1'b1;
                send_frame(8'($urandom_range(0, 255)), 16'd60, 1'b0);
                tx_steady    = 1'b0;
            end
            phase_end = bytes_sent + PHASE_ITEMS;
            while (bytes_sent < phase_end) send_episode();
            phase_no++;
        end

        settle_block();
        repeat (8) @(posedge aclk);
        $display("Sent %0d bytes over %0d start-byte settings, with idle gaps on both sides",
                 bytes_sent, settings_used);
        $display("Checked %0d results: %0d payload bytes, %0d good, %0d bad, %0d mismatches",
                 tracker.checked, tracker.payload_seen, tracker.good_frames,
                 tracker.bad_frames, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
            $display("[frame_deframer_sum_checksum] OK");
        end else begin
            $display("[frame_deframer_sum_checksum] ERROR");
        end
        $finish;
    end

endmodule

// ----- frame_deframer_sum_checksum.f -----
hdl/fdsc_pkg.sv
hdl/fdsc_deframer.sv
hdl/fdsc_skid.sv
hdl/frame_deframer_sum_checksum.sv
sim/tb_top.sv
